FILE: hw/rtl/countdown_alarm_bank_assert.svh
// Assertion macros used by the alarm bank datapath.
`ifndef COUNTDOWN_ALARM_BANK_ASSERT_SVH
`define COUNTDOWN_ALARM_BANK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm bank assertion failed");

// Next-cycle implication, checked outside reset.
`define CAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm bank assertion failed");

`endif

FILE: hw/rtl/cab_pkg.sv
`timescale 1ns / 1ps

package cab_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SET    = 3'd2,
        OP_CANCEL = 3'd3,
        OP_QUERY  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_EXPIRED = 3'd2,
        KIND_QUERY   = 3'd3,
        KIND_BAD_ID  = 3'd4,
        KIND_DONE    = 3'd5
    } t_kind;

    // Source of the slot number in a result.
    typedef enum logic [1:0] {
        SLOT_NONE = 2'd0,
        SLOT_ID   = 2'd1,
        SLOT_NEW  = 2'd2,
        SLOT_PEND = 2'd3
    } t_slot_sel;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DECODE   = 3'd1,
        ST_QUERY    = 3'd2,
        ST_TICK_RD  = 3'd3,
        ST_TICK_UPD = 3'd4,
        ST_TICK_END = 3'd5
    } t_state;

    typedef struct packed {
        logic      capture;
        logic      wr_add;
        logic      wr_set;
        logic      wr_cancel;
        logic      rd_id;
        logic      rd_walk;
        logic      walk_clr;
        logic      walk_inc;
        logic      tick_wr;
        logic      pend_set;
        logic      pend_clr;
        logic      out_load;
        t_kind     out_kind;
        t_slot_sel out_slot;
        logic      out_counts;
        logic      out_last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic id_ok;
        logic full;
        logic count_zero;
        logic walk_last;
        logic running;
        logic fire;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/cab_ctrl.sv
`timescale 1ns / 1ps

module cab_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cab_pkg::t_status  i_status,
    output cab_pkg::t_cmd     o_cmd
);
    import cab_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end

            ST_DECODE: begin
                unique case (i_status.op)
                    OP_TICK: begin
                        if (i_status.count_zero) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.walk_clr = 1'b1;
                            n_state        = ST_TICK_RD;
                        end
                    end
                    OP_ADD: begin
                        if (i_status.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_status.full) begin
                                o_cmd.out_kind = KIND_FULL;
                                o_cmd.out_slot = SLOT_NONE;
                            end else begin
                                o_cmd.wr_add   = 1'b1;
                                o_cmd.out_kind = KIND_ADDED;
                                o_cmd.out_slot = SLOT_NEW;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    OP_SET, OP_CANCEL: begin
                        if (i_status.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (!i_status.id_ok) begin
                                o_cmd.out_kind = KIND_BAD_ID;
                                o_cmd.out_slot = SLOT_NONE;
                            end else begin
                                o_cmd.wr_set    = (i_status.op == OP_SET);
                                o_cmd.wr_cancel = (i_status.op == OP_CANCEL);
                                o_cmd.out_kind  = KIND_DONE;
                                o_cmd.out_slot  = SLOT_ID;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (i_status.id_ok) begin
                            o_cmd.rd_id = 1'b1;
                            n_state     = ST_QUERY;
                        end else if (i_status.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            o_cmd.out_kind = KIND_BAD_ID;
                            o_cmd.out_slot = SLOT_NONE;
                            n_state        = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_QUERY: begin
                if (i_status.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_kind   = KIND_QUERY;
                    o_cmd.out_slot   = SLOT_ID;
                    o_cmd.out_counts = 1'b1;
                    n_state          = ST_IDLE;
                end
            end

            ST_TICK_RD: begin
                o_cmd.rd_walk = 1'b1;
                n_state       = ST_TICK_UPD;
            end

            ST_TICK_UPD: begin
                // An expiry with a result already held must wait for room
                // at the output before the slot is written back.
                if (!(i_status.running && i_status.fire && i_status.pend_valid
                      && !i_status.out_free)) begin
                    if (i_status.running) begin
                        o_cmd.tick_wr = 1'b1;
                        if (i_status.fire) begin
                            o_cmd.pend_set = 1'b1;
                            if (i_status.pend_valid) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = KIND_EXPIRED;
                                o_cmd.out_slot = SLOT_PEND;
                            end
                        end
                    end
                    if (i_status.walk_last) begin
                        n_state = ST_TICK_END;
                    end else begin
                        o_cmd.walk_inc = 1'b1;
                        n_state        = ST_TICK_RD;
                    end
                end
            end

            ST_TICK_END: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_kind = KIND_EXPIRED;
                    o_cmd.out_slot = SLOT_PEND;
                    o_cmd.pend_clr = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cab_datapath.sv
`timescale 1ns / 1ps

module cab_datapath #(
    parameter int unsigned MAX_ALARMS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cab_pkg::t_cmd     i_cmd,
    output cab_pkg::t_status  o_status,
    input  logic [2:0]        i_operation,
    input  logic [3:0]        i_alarm_id,
    input  logic [31:0]       i_period_ms,
    input  logic              i_reload,
    input  logic              i_notify,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_kind,
    output logic [3:0]        o_slot_id,
    output logic [31:0]       o_remaining,
    output logic [31:0]       o_elapsed_ticks,
    output logic              o_last
);
    import cab_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ALARMS + 1);
    localparam int unsigned IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int unsigned EXT_W = (CNT_W > 4) ? CNT_W : 4;

    // Captured transaction.
    t_op         r_op;
    logic [3:0]  r_id;
    logic [31:0] r_period;
    logic        r_reload;
    logic        r_notify;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_walk;
    logic             r_pend_valid;
    logic [3:0]       r_pend_slot;

    // Per-slot stores, contents undefined until an add writes them.
    logic [31:0] r_rem_mem  [MAX_ALARMS];
    logic [31:0] r_per_mem  [MAX_ALARMS];
    logic [1:0]  r_flag_mem [MAX_ALARMS];

    logic [31:0] r_rd_rem;
    logic [31:0] r_rd_per;
    logic [1:0]  r_rd_flags;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [3:0]  r_out_slot;
    logic [31:0] r_out_rem;
    logic [31:0] r_out_ela;
    logic        r_out_last;

    logic [EXT_W-1:0] id_ext;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] new_slot_ext;
    logic [EXT_W-1:0] walk_slot_ext;
    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] cnt_idx;
    logic [CNT_W-1:0] walk_next;
    logic             id_ok;
    logic             full;
    logic             expire;
    logic             out_free;
    logic [31:0]      tick_rem;
    logic             rem_we;
    logic             per_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      rem_wdata;
    logic [31:0]      per_wdata;
    logic [IDX_W-1:0] rd_addr;
    logic [3:0]       slot_sel_val;

    assign id_ext        = EXT_W'(r_id);
    assign cnt_ext       = EXT_W'(r_count);
    assign new_slot_ext  = cnt_ext + EXT_W'(1);
    assign walk_slot_ext = EXT_W'(r_walk) + EXT_W'(1);
    assign id_idx        = IDX_W'(id_ext - EXT_W'(1));
    assign cnt_idx       = IDX_W'(r_count);
    assign walk_next     = CNT_W'(r_walk) + CNT_W'(1);
    assign id_ok         = (r_id != 4'd0) && (id_ext <= cnt_ext);
    assign full          = (r_count == CNT_W'(MAX_ALARMS));
    assign expire        = (r_rd_rem == 32'd1);
    assign out_free      = !r_out_valid || !i_out_stall;

    // Countdown step; a reload slot restarts from its period on expiry.
    assign tick_rem = (expire && r_rd_flags[1]) ? r_rd_per : (r_rd_rem - 32'd1);

    assign rem_we = i_cmd.wr_add || i_cmd.wr_set || i_cmd.wr_cancel || i_cmd.tick_wr;
    assign per_we = i_cmd.wr_add || i_cmd.wr_set || i_cmd.wr_cancel;
    assign rd_addr = i_cmd.rd_id ? id_idx : r_walk;

    always_comb begin
        priority if (i_cmd.wr_add) begin
            wr_addr   = cnt_idx;
            rem_wdata = r_period;
            per_wdata = r_period;
        end else if (i_cmd.wr_set) begin
            wr_addr   = id_idx;
            rem_wdata = r_period;
            per_wdata = r_period;
        end else if (i_cmd.wr_cancel) begin
            wr_addr   = id_idx;
            rem_wdata = 32'd0;
            per_wdata = 32'd0;
        end else begin
            wr_addr   = r_walk;
            rem_wdata = tick_rem;
            per_wdata = r_period;
        end
    end

    always_comb begin
        unique case (i_cmd.out_slot)
            SLOT_NONE: slot_sel_val = 4'd0;
            SLOT_ID:   slot_sel_val = r_id;
            SLOT_NEW:  slot_sel_val = new_slot_ext[3:0];
            SLOT_PEND: slot_sel_val = r_pend_slot;
            default:   slot_sel_val = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[wr_addr] <= rem_wdata;
        end
        if (per_we) begin
            r_per_mem[wr_addr] <= per_wdata;
        end
        if (i_cmd.wr_add) begin
            r_flag_mem[wr_addr] <= {r_reload, r_notify};
        end
        if (i_cmd.rd_id || i_cmd.rd_walk) begin
            r_rd_rem   <= r_rem_mem[rd_addr];
            r_rd_per   <= r_per_mem[rd_addr];
            r_rd_flags <= r_flag_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_operation);
            r_id     <= i_alarm_id;
            r_period <= i_period_ms;
            r_reload <= i_reload;
            r_notify <= i_notify;
        end
        if (i_cmd.walk_clr) begin
            r_walk <= '0;
        end else if (i_cmd.walk_inc) begin
            r_walk <= r_walk + IDX_W'(1);
        end
        if (i_cmd.pend_set) begin
            r_pend_slot <= walk_slot_ext[3:0];
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_slot <= slot_sel_val;
            r_out_rem  <= i_cmd.out_counts ? r_rd_rem : 32'd0;
            r_out_ela  <= i_cmd.out_counts ? (r_rd_per - r_rd_rem) : 32'd0;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.wr_add) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.op         = r_op;
        o_status.id_ok      = id_ok;
        o_status.full       = full;
        o_status.count_zero = (r_count == '0);
        o_status.walk_last  = (walk_next == r_count);
        o_status.running    = (r_rd_rem != 32'd0);
        o_status.fire       = expire && r_rd_flags[0];
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_slot_id       = r_out_slot;
    assign o_remaining     = r_out_rem;
    assign o_elapsed_ticks = r_out_ela;
    assign o_last          = r_out_last;

`include "countdown_alarm_bank_assert.svh"

    `CAB_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ALARMS))
    `CAB_ASSERT_NOW(a_add_not_full, i_clk, i_rst_n, i_cmd.wr_add, !full)
    `CAB_ASSERT_NOW(a_tick_running, i_clk, i_rst_n, i_cmd.tick_wr, r_rd_rem != 32'd0)
    `CAB_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, out_free)
    `CAB_ASSERT_NEXT(a_pend_drained, i_clk, i_rst_n, i_cmd.pend_clr, !r_pend_valid)

endmodule

FILE: hw/rtl/countdown_alarm_bank.sv
`timescale 1ns / 1ps
// An add, set or cancel result is loaded into the output register in the decode state, a query
// reply in the query state after the slot read; the final expiry of a tick follows the end of
// the slot walk. Transactions are taken one at a time; a state that must load a result waits
// while the output register is full and stalled.
// Each slot visited by a tick is read in ST_TICK_RD and, if still counting, written back in ST_TICK_UPD.
// Reset (synchronous, active low) empties the bank, clears control and output valid only.

module countdown_alarm_bank #(
    parameter int unsigned MAX_ALARMS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_alarm_id,
    input  logic [31:0] i_period_ms,
    input  logic        i_reload,
    input  logic        i_notify,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot_id,
    output logic [31:0] o_remaining,
    output logic [31:0] o_elapsed_ticks,
    output logic        o_last
);
    import cab_pkg::*;

    // The controller sequences each transaction; the datapath holds the slot
    // memories, the slot count, the tick walk index and the output register.
    // During a tick, each expiry result is held back by one expiry so that the
    // final result of the tick can carry the last flag.
    t_cmd    cmd;
    t_status status;

    cab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The output register sits in the datapath, so a new transaction can be
    // taken while an earlier result still waits at the output.
    cab_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_operation     (i_operation),
        .i_alarm_id      (i_alarm_id),
        .i_period_ms     (i_period_ms),
        .i_reload        (i_reload),
        .i_notify        (i_notify),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_slot_id       (o_slot_id),
        .o_remaining     (o_remaining),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_last          (o_last)
    );

endmodule

FILE: tb/countdown_alarm_bank_tb.sv
`timescale 1ns / 1ps

module countdown_alarm_bank_tb;
    import cab_pkg::*;

    // The bank is built with eight slots, so a single tick can expire every slot at once.
    localparam int BANK_SLOTS = 8;

    // Operation codes 5 to 7 have no meaning; the block must swallow them silently.
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    // Run shape. The watchdog limit leaves a wide margin over the quiet stretch on both sides
    // that a full tick with eight stalled expiries can cause.
    localparam int RANDOM_ITEMS   = 235;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_WAIT       = 16;

    // Index into the idle bookkeeping for the two channels.
    localparam int SIDE_IN  = 0;
    localparam int SIDE_OUT = 1;

    // One result transaction as it leaves the block.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [31:0] remaining;
        logic [31:0] elapsed;
        logic        last;
    } t_alarm_event;

    // One row of the directed table. Where typed is set, the row carries its single
    // expected result by hand; otherwise the predictor supplies the expectation.
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  id;
        logic [31:0] period;
        logic        reload;
        logic        notify;
        logic        typed;
        t_kind       kind;
        logic [3:0]  slot;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_operation = '0;
    logic [3:0]  i_alarm_id = '0;
    logic [31:0] i_period_ms = '0;
    logic        i_reload = 1'b0;
    logic        i_notify = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [3:0]  o_slot_id;
    logic [31:0] o_remaining;
    logic [31:0] o_elapsed_ticks;
    logic        o_last;

    countdown_alarm_bank #(
        .MAX_ALARMS(BANK_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_alarm_id     (i_alarm_id),
        .i_period_ms    (i_period_ms),
        .i_reload       (i_reload),
        .i_notify       (i_notify),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot_id      (o_slot_id),
        .o_remaining    (o_remaining),
        .o_elapsed_ticks(o_elapsed_ticks),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the alarm bank. Only allocated slots are ever read, so the per-slot
    // arrays need no reset value of their own.
    int          slots_used = 0;
    logic [31:0] ticks_left [BANK_SLOTS];
    logic [31:0] period_of  [BANK_SLOTS];
    logic        reload_of  [BANK_SLOTS];
    logic        notify_of  [BANK_SLOTS];

    t_alarm_event step_events[$];     // results of the transaction just accepted
    t_alarm_event awaited_events[$];  // results still to come out of the block, oldest first

    int fail_count = 0;
    int quiet_cycles = 0;
    int calm_left[2] = '{0, 0};
    int out_hold = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Idle cycles before the next transaction on one side. Now and then a side enters a
    // calm stretch of back-to-back transactions, so both heavy and zero idling are seen.
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 5) == 0) calm_left[side] = $urandom_range(8, 24);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void note_event(input t_kind kind, input logic [3:0] slot,
                                       input logic [31:0] remaining, input logic [31:0] elapsed);
        t_alarm_event ev;
        ev.kind = kind;
        ev.slot = slot;
        ev.remaining = remaining;
        ev.elapsed = elapsed;
        ev.last = 1'b0;
        step_events.push_back(ev);
    endfunction

    // Advances the shadow bank by one transaction and leaves its results in step_events,
    // with the last flag on the final one.
    function automatic void advance_alarm_bank(input logic [2:0] op, input logic [3:0] id,
                                               input logic [31:0] period, input logic reload,
                                               input logic notify);
        t_alarm_event ev;
        int s;
        step_events.delete();
        s = int'(id) - 1;
        case (op)
            OP_TICK: begin
                // Slots are walked in order, so expiries come out lowest slot first.
                for (int i = 0; i < slots_used; i++) begin
                    if (ticks_left[i] != 32'd0) begin
                        ticks_left[i] = ticks_left[i] - 32'd1;
                        if (ticks_left[i] == 32'd0) begin
                            if (notify_of[i]) note_event(KIND_EXPIRED, 4'(i + 1), '0, '0);
                            if (reload_of[i]) ticks_left[i] = period_of[i];
                        end
                    end
                end
            end
            OP_ADD: begin
                if (slots_used < BANK_SLOTS) begin
                    ticks_left[slots_used] = period;
                    period_of[slots_used] = period;
                    reload_of[slots_used] = reload;
                    notify_of[slots_used] = notify;
                    slots_used++;
                    note_event(KIND_ADDED, 4'(slots_used), '0, '0);
                end else begin
                    note_event(KIND_FULL, 4'd0, '0, '0);
                end
            end
            OP_SET, OP_CANCEL, OP_QUERY: begin
                if (id == 4'd0 || int'(id) > slots_used) begin
                    note_event(KIND_BAD_ID, 4'd0, '0, '0);
                end else if (op == OP_SET) begin
                    ticks_left[s] = period;
                    period_of[s] = period;
                    note_event(KIND_DONE, id, '0, '0);
                end else if (op == OP_CANCEL) begin
                    ticks_left[s] = '0;
                    period_of[s] = '0;
                    note_event(KIND_DONE, id, '0, '0);
                end else begin
                    note_event(KIND_QUERY, id, ticks_left[s], period_of[s] - ticks_left[s]);
                end
            end
            default: ;
        endcase
        if (step_events.size() > 0) begin
            ev = step_events[step_events.size() - 1];
            ev.last = 1'b1;
            step_events[step_events.size() - 1] = ev;
        end
    endfunction

    // Presents one transaction, holds it until it is taken, then files what it should
    // produce. Valid stays high into the next transaction when no idle cycles are drawn,
    // so it is never lowered and raised at the same edge.
    task automatic send_item(input t_stim_row row);
        int gap;
        t_alarm_event ev;
        gap = draw_wait(SIDE_IN);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= row.op;
        i_alarm_id <= row.id;
        i_period_ms <= row.period;
        i_reload <= row.reload;
        i_notify <= row.notify;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // The predictor always runs so that the shadow bank tracks the block, even where
        // the row states its result by hand.
        advance_alarm_bank(row.op, row.id, row.period, row.reload, row.notify);
        if (row.typed) begin
            ev.kind = row.kind;
            ev.slot = row.slot;
            ev.remaining = '0;
            ev.elapsed = '0;
            ev.last = 1'b1;
            awaited_events.push_back(ev);
        end else begin
            foreach (step_events[k]) awaited_events.push_back(step_events[k]);
        end
    endtask

    // Directed opening: bad ids on an empty bank, ignored codes, filling every slot with the
    // flag combinations and period extremes, the bank-full case, ticks that expire several
    // slots at once with and without reload, and set and cancel on allocated slots.
    t_stim_row directed_rows[25] = '{
        '{OP_QUERY,      4'd1,  32'd0,          1'b0, 1'b0, 1'b1, KIND_BAD_ID, 4'd0},
        '{OP_SET,        4'd0,  32'd5,          1'b0, 1'b0, 1'b1, KIND_BAD_ID, 4'd0},
        '{OP_CANCEL,     4'd15, 32'd0,          1'b0, 1'b0, 1'b1, KIND_BAD_ID, 4'd0},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_RSVD_FIRST, 4'd1,  32'd9,          1'b1, 1'b1, 1'b0, KIND_DONE,   4'd0},
        '{OP_ADD,        4'd0,  32'd0,          1'b0, 1'b1, 1'b1, KIND_ADDED,  4'd1},
        '{OP_ADD,        4'd0,  32'd1,          1'b1, 1'b1, 1'b1, KIND_ADDED,  4'd2},
        '{OP_ADD,        4'd0,  32'd2,          1'b1, 1'b0, 1'b1, KIND_ADDED,  4'd3},
        '{OP_ADD,        4'd0,  32'hFFFF_FFFF,  1'b0, 1'b1, 1'b1, KIND_ADDED,  4'd4},
        '{OP_ADD,        4'd0,  32'd3,          1'b0, 1'b1, 1'b1, KIND_ADDED,  4'd5},
        '{OP_ADD,        4'd0,  32'd1,          1'b0, 1'b0, 1'b1, KIND_ADDED,  4'd6},
        '{OP_ADD,        4'd0,  32'd2,          1'b1, 1'b1, 1'b1, KIND_ADDED,  4'd7},
        '{OP_ADD,        4'd15, 32'd1,          1'b1, 1'b1, 1'b1, KIND_ADDED,  4'd8},
        '{OP_ADD,        4'd0,  32'd7,          1'b1, 1'b1, 1'b1, KIND_FULL,   4'd0},
        '{OP_QUERY,      4'd4,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_QUERY,      4'd0,  32'd0,          1'b0, 1'b0, 1'b1, KIND_BAD_ID, 4'd0},
        '{OP_QUERY,      4'd9,  32'd0,          1'b0, 1'b0, 1'b1, KIND_BAD_ID, 4'd0},
        '{OP_SET,        4'd8,  32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, KIND_DONE,   4'd8},
        '{OP_CANCEL,     4'd2,  32'd0,          1'b0, 1'b0, 1'b1, KIND_DONE,   4'd2},
        '{OP_QUERY,      4'd2,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_QUERY,      4'd8,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_TICK,       4'd0,  32'd0,          1'b0, 1'b0, 1'b0, KIND_DONE,   4'd0},
        '{OP_RSVD_LAST,  4'd3,  32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, KIND_DONE,   4'd0}
    };

    // Random part. The bank is full after the directed part, so most of the mix is ticks,
    // queries and sets with short periods, which keeps slots expiring. Occasional long
    // periods, cancels, bad ids, adds on a full bank and unknown codes make up the rest.
    task automatic run_random_items();
        t_stim_row row;
        int counted;
        int pick;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) row.op = OP_TICK;
            else if (pick < 65) row.op = OP_QUERY;
            else if (pick < 80) row.op = OP_SET;
            else if (pick < 86) row.op = OP_CANCEL;
            else if (pick < 92) row.op = OP_ADD;
            else row.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            if ($urandom_range(0, 6) == 0) row.id = 4'($urandom_range(0, 15));
            else row.id = 4'($urandom_range(1, BANK_SLOTS));
            pick = $urandom_range(0, 9);
            if (pick == 0) row.period = $urandom();
            else if (pick == 1) row.period = 32'($urandom_range(7, 40));
            else row.period = 32'($urandom_range(0, 6));
            row.reload = 1'($urandom_range(0, 1));
            row.notify = 1'($urandom_range(0, 1));
            row.typed = 1'b0;
            row.kind = KIND_DONE;
            row.slot = 4'd0;
            send_item(row);
            counted++;
        end
    endtask

    // Result side: every accepted result is checked against the oldest expectation, then
    // the receiver draws how long it will hold off before the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_events.size() == 0) begin
                    report_mismatch("result with nothing expected, kind", 32'(o_kind), '0);
                end else begin
                    if (o_kind !== awaited_events[0].kind)
                        report_mismatch("kind", 32'(o_kind), 32'(awaited_events[0].kind));
                    if (o_slot_id !== awaited_events[0].slot)
                        report_mismatch("slot_id", 32'(o_slot_id), 32'(awaited_events[0].slot));
                    if (o_remaining !== awaited_events[0].remaining)
                        report_mismatch("remaining", o_remaining, awaited_events[0].remaining);
                    if (o_elapsed_ticks !== awaited_events[0].elapsed)
                        report_mismatch("elapsed_ticks", o_elapsed_ticks,
                                        awaited_events[0].elapsed);
                    if (o_last !== awaited_events[0].last)
                        report_mismatch("last", 32'(o_last), 32'(awaited_events[0].last));
                    void'(awaited_events.pop_front());
                end
                out_hold = draw_wait(SIDE_OUT);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold > 0);
        end
    end

    // Watchdog: a run in which nothing moves on either channel for too long has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) send_item(directed_rows[r]);
        run_random_items();
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        // A trailing tick may still be walking the slots with no result to show for it.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cab_pkg.sv
hw/rtl/cab_ctrl.sv
hw/rtl/cab_datapath.sv
hw/rtl/countdown_alarm_bank.sv
tb/countdown_alarm_bank_tb.sv
